// ===== rtl/core/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and controller/datapath interface types for the
// text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int CELLS     = COLUMNS * ROWS;
  localparam int COPY_N    = (ROWS - 1) * COLUMNS;
  localparam int CELL_W    = $clog2(CELLS);
  localparam int COL_W     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int CELLV_W   = 16;

  // Port field widths
  localparam int CHAR_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int POS_W     = 11;
  localparam int COUNT_W   = 32;
  localparam int ATTR_W    = 8;
  localparam int IN_DATA_W  = 24;  // char_code + cell_index, padded to bytes
  localparam int OUT_DATA_W = 72;  // result fields, exact byte multiple

  // Character codes
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  // Command codes
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_step;    // write zero at sweep pointer, advance
    logic accept;      // latch input beat, launch cell read
    logic exec;        // apply item, load result register
    logic prime;       // launch first scroll read
    logic scroll_step; // move one cell up or write blank, advance
  } tcw_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;    // result register can take a new result
    logic need_scroll; // latched item pushes cursor past last cell
    logic sweep_last;  // sweep pointer at last cell
  } tcw_stat_t;

endpackage

// ===== rtl/core/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Text console engine over an 80x25 store of attribute/glyph cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per command. tuser is the command (put or read), tlast
//           marks the final byte of a write call, tdata carries the byte and
//           the cell index of a read.
//   out_* : one result beat per input beat, in order.
//   cfg_* : attribute byte for glyphs and scroll fill; always ready, write
//           only while the block is idle.
// Timing: an item is accepted, then executed into the result register; the
//   block takes no new item until the last one has executed. A cell read
//   uses the registered read port of the cell RAM launched at accept.
//   An item that moves the cursor past the last cell triggers a scroll sweep
//   through the single RAM write port, with in_tready low; its result is
//   already presented during the sweep.
// Reset: cursor, hardware cursor and count clear, the attribute returns to
//   0x07, and a clearing pass writes zero to all 2000 cells, with
//   in_tready low.
// Stall: a result waits in the output register; the next item is accepted
//   meanwhile and holds in execute until out_tready frees the register.
// ----------------------------------------------------------------------------
module text_console_writer
  import tcw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,  // [7:0] char_code, [18:8] cell_index
  input  logic                  in_tuser,  // [0] command
  input  logic                  in_tlast,
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata, // [10:0] cursor_position,
                                           // [21:11] hardware_cursor,
                                           // [22] cursor_updated, [23] counted,
                                           // [55:24] written_count,
                                           // [71:56] cell_value
  // configuration
  input  logic                  cfg_tvalid,
  output logic                  cfg_tready,
  input  logic [ATTR_W-1:0]     cfg_tdata  // [7:0] text_attribute
);

  tcw_cmd_t  cmd;
  tcw_stat_t stat;

  assign cfg_tready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tcw_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_command      (in_tuser),
    .in_char_code    (in_tdata[CHAR_W-1:0]),
    .in_last_of_call (in_tlast),
    .in_cell_index   (in_tdata[CHAR_W+INDEX_W-1:CHAR_W]),
    .cfg_we          (cfg_tvalid && cfg_tready),
    .cfg_attr        (cfg_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata)
  );

endmodule

// ===== rtl/core/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer for the console: clearing pass, item accept/execute and the
// scroll sweep.
// ----------------------------------------------------------------------------
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  tcw_stat_t stat,
  output tcw_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_EXEC   = 5'b00100,
    ST_PRIME  = 5'b01000,
    ST_SCROLL = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result register has room
        if (stat.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = stat.need_scroll ? ST_PRIME : ST_IDLE;
        end
      end
      ST_PRIME: begin
        cmd.prime = 1'b1;
        state_nxt = ST_SCROLL;
      end
      ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/tcw_dp.sv =====
// ----------------------------------------------------------------------------
// tcw_dp
// Console datapath: cell store, cursor tracking, call counter, attribute
// register and the result register.
// ----------------------------------------------------------------------------
module tcw_dp
  import tcw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  tcw_cmd_t              cmd,
  output tcw_stat_t             stat,
  // input beat fields
  input  logic                  in_command,
  input  logic [CHAR_W-1:0]     in_char_code,
  input  logic                  in_last_of_call,
  input  logic [INDEX_W-1:0]    in_cell_index,
  // configuration
  input  logic                  cfg_we,
  input  logic [ATTR_W-1:0]     cfg_attr,
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam logic [CELL_W-1:0] LAST_BASE = CELL_W'(COPY_N);
  localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);
  localparam logic [CELL_W-1:0] COPY_END  = CELL_W'(COPY_N - 1);
  localparam logic [CELL_W-1:0] ROW_STEP  = CELL_W'(COLUMNS);
  localparam logic [CELL_W-1:0] READ_OFS  = CELL_W'(COLUMNS + 1);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);

  // latched item
  logic              cmd_r;
  logic [CHAR_W-1:0] ch_r;
  logic              last_r;
  logic              oor_r;

  logic [ATTR_W-1:0] attr_r;
  logic [CELL_W-1:0] cur_r, cur_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [CELL_W-1:0] shown_r;
  logic [COUNT_W-1:0] count_r, count_inc;
  logic [CELL_W-1:0] ptr_r;

  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // RAM ports
  logic               we;
  logic [CELL_W-1:0]  waddr;
  logic [CELLV_W-1:0] wdata;
  logic               re;
  logic [CELL_W-1:0]  raddr;
  logic [CELLV_W-1:0] rdata;

  logic is_put, is_cr, is_lf, is_glyph, counted;
  logic [CELLV_W-1:0] blank;
  logic [CELLV_W-1:0] cell_val;

  tcw_ram #(
    .WIDTH (CELLV_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign is_put   = (cmd_r == CMD_PUT);
  assign is_cr    = is_put && (ch_r == CH_CR);
  assign is_lf    = is_put && (ch_r == CH_LF);
  assign is_glyph = is_put && !is_cr && !is_lf;
  assign counted  = is_lf || is_glyph;
  assign blank    = {attr_r, CH_SPACE};

  assign stat.out_free    = !out_valid_r || out_tready;
  assign stat.sweep_last  = (ptr_r == LAST_CELL);
  assign stat.need_scroll = (row_r == ROW_LAST) &&
                            (is_lf || (is_glyph && (col_r == COL_LAST)));

  // cursor update
  always_comb begin
    cur_nxt = cur_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (is_cr) begin
      cur_nxt = cur_r - CELL_W'(col_r);
      col_nxt = '0;
    end else if (is_lf || (is_glyph && (col_r == COL_LAST))) begin
      col_nxt = '0;
      if (row_r == ROW_LAST) begin
        // scroll pulls the cursor back to the start of the last row
        cur_nxt = LAST_BASE;
      end else begin
        cur_nxt = is_lf ? (cur_r - CELL_W'(col_r) + ROW_STEP) : (cur_r + CELL_W'(1));
        row_nxt = row_r + ROW_W'(1);
      end
    end else if (is_glyph) begin
      cur_nxt = cur_r + CELL_W'(1);
      col_nxt = col_r + COL_W'(1);
    end
  end

  assign count_inc = (count_r != '1) ? (count_r + COUNT_W'(1)) : count_r;
  assign cell_val  = (!is_put && !oor_r) ? rdata : '0;

  always_comb begin
    out_data_nxt = {cell_val,
                    counted ? count_inc : count_r,
                    counted,
                    counted,
                    counted ? POS_W'(cur_nxt) : POS_W'(shown_r),
                    POS_W'(cur_nxt)};
  end

  // RAM port selection
  always_comb begin
    we    = 1'b0;
    waddr = ptr_r;
    wdata = '0;
    re    = 1'b0;
    raddr = CELL_W'(in_cell_index);
    if (cmd.clr_step) begin
      we = 1'b1;
    end
    if (cmd.accept) begin
      re = 1'b1;
    end
    if (cmd.exec && is_glyph) begin
      we    = 1'b1;
      waddr = cur_r;
      wdata = {attr_r, ch_r};
    end
    if (cmd.prime) begin
      re    = 1'b1;
      raddr = ROW_STEP;
    end
    if (cmd.scroll_step) begin
      we    = 1'b1;
      wdata = (ptr_r < LAST_BASE) ? rdata : blank;
      re    = (ptr_r < COPY_END);
      raddr = ptr_r + READ_OFS;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r  <= in_command;
      ch_r   <= in_char_code;
      last_r <= in_last_of_call;
      oor_r  <= (32'(in_cell_index) >= CELLS);
    end
    if (cmd.exec) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= ATTR_RESET;
      cur_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      shown_r     <= '0;
      count_r     <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr_r <= cfg_attr;
      end
      if (cmd.exec) begin
        cur_r       <= cur_nxt;
        col_r       <= col_nxt;
        row_r       <= row_nxt;
        out_valid_r <= 1'b1;
        if (counted) begin
          shown_r <= cur_nxt;
        end
        // count clears after the beat marked last
        if (last_r) begin
          count_r <= '0;
        end else if (counted) begin
          count_r <= count_inc;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.prime) begin
        ptr_r <= '0;
      end else if (cmd.clr_step || cmd.scroll_step) begin
        ptr_r <= stat.sweep_last ? '0 : (ptr_r + CELL_W'(1));
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/core/tcw_check.sv =====
// ----------------------------------------------------------------------------
// tcw_check
// Port-level checks for the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_check
  import tcw_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // one item at a time: no accept right after an accept
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on back-to-back cycles");

  // cursor stays inside the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[10:0]) < CELLS))
    else $error("cursor beyond last cell");

  // counted bytes and only they push the cursor to the display
  a_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[22] == out_tdata[23]) &&
                   (!out_tdata[22] || (out_tdata[21:11] == out_tdata[10:0])))
    else $error("hardware cursor update mismatch");

endmodule

bind text_console_writer tcw_check u_tcw_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== dv/text_console_writer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Self-checking bench for the text console writer. Drives put and read beats
// with random gaps and output stalls, keeps a shadow copy of the cell store,
// cursors, call count and attribute, and compares every result beat field by
// field against the shadow in order. Attribute writes happen only while idle.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int SWEEP_CYCLES = CELLS + 1;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int MAX_INDEX    = (1 << INDEX_W) - 1;

  // Field order matches out_tdata, highest bits first
  typedef struct packed {
    logic [CELLV_W-1:0] cell_word;
    logic [COUNT_W-1:0] total;
    logic               counted;
    logic               updated;
    logic [POS_W-1:0]   shown_pos;
    logic [POS_W-1:0]   cursor_pos;
  } console_status_t;

  class console_shadow;
    logic [CELLV_W-1:0] cells [CELLS];
    int unsigned        cursor;
    int unsigned        shown;
    logic [COUNT_W-1:0] call_total;
    logic [ATTR_W-1:0]  attr;
    console_status_t    due_status [$];
    int unsigned        bad_beats;

    function new();
      foreach (cells[i]) cells[i] = '0;
      cursor     = 0;
      shown      = 0;
      call_total = '0;
      attr       = ATTR_RESET;
      bad_beats  = 0;
    endfunction

    // Shift rows up and blank the last row once the cursor runs off the end
    function void scroll_if_full();
      if (cursor < CELLS) return;
      for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = {attr, CH_SPACE};
      cursor -= COLUMNS;
    endfunction

    function void apply_command(input logic cmd, input logic [CHAR_W-1:0] ch,
                                input logic last, input logic [INDEX_W-1:0] idx);
      console_status_t st;
      st = '0;
      if (cmd == CMD_READ) begin
        if (idx < CELLS) st.cell_word = cells[idx];
      end else if (ch == CH_CR) begin
        cursor = (cursor / COLUMNS) * COLUMNS;
      end else begin
        if (ch == CH_LF) begin
          cursor = (cursor / COLUMNS + 1) * COLUMNS;
        end else begin
          scroll_if_full();
          cells[cursor] = {attr, ch};
          cursor++;
        end
        scroll_if_full();
        shown      = cursor;
        st.updated = 1'b1;
        st.counted = 1'b1;
        if (call_total != '1) call_total++;
      end
      st.cursor_pos = POS_W'(cursor);
      st.shown_pos  = POS_W'(shown);
      st.total      = call_total;
      due_status.push_back(st);
      if (last) call_total = '0;
    endfunction

    function void compare_status(input console_status_t got);
      console_status_t want;
      if (due_status.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10) $display("unexpected result beat: %h", got);
        return;
      end
      want = due_status.pop_front();
      if (got.cursor_pos !== want.cursor_pos || got.shown_pos !== want.shown_pos ||
          got.updated !== want.updated || got.counted !== want.counted ||
          got.total !== want.total || got.cell_word !== want.cell_word) begin
        bad_beats++;
        if (bad_beats <= 10) begin
          $display("mismatch exp: cur=%0d hw=%0d upd=%0b cnt=%0b total=%0d cell=%h",
                   want.cursor_pos, want.shown_pos, want.updated, want.counted,
                   want.total, want.cell_word);
          $display("         got: cur=%0d hw=%0d upd=%0b cnt=%0b total=%0d cell=%h",
                   got.cursor_pos, got.shown_pos, got.updated, got.counted,
                   got.total, got.cell_word);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // [7:0] char_code, [18:8] cell_index
  logic                  in_tuser   = 1'b0; // [0] command
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // [10:0] cursor, [21:11] hw cursor, [22] updated,
                                     // [23] counted, [55:24] count, [71:56] cell
  logic                  cfg_tvalid = 1'b0;
  logic                  cfg_tready;
  logic [ATTR_W-1:0]     cfg_tdata  = '0; // [7:0] text_attribute

  console_shadow shadow;
  bit            gaps_on = 1'b1;
  int            ready_hold = 0;
  int unsigned   cycles = 0;

  text_console_writer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Check result beats and stall the result side in bursts
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) shadow.compare_status(out_tdata);
    if (!gaps_on) begin
      out_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 15) == 0) begin
      ready_hold = $urandom_range(0, 12);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic put_beat(input logic cmd, input logic [CHAR_W-1:0] ch,
                          input logic [INDEX_W-1:0] idx, input logic last);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tlast  <= last;
    in_tdata  <= {{(IN_DATA_W - INDEX_W - CHAR_W){1'b0}}, idx, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    shadow.apply_command(cmd, ch, last, idx);
  endtask

  task automatic write_attr(input logic [ATTR_W-1:0] value);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= value;
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    cfg_tvalid <= 1'b0;
    shadow.attr = value;
  endtask

  // Drop valid, drain all results, then let a possible scroll sweep finish
  task automatic settle();
    in_tvalid <= 1'b0;
    while (shadow.due_status.size() != 0) @(posedge clk);
    repeat (SWEEP_CYCLES + 100) @(posedge clk);
  endtask

  // Write calls of random length; mostly glyphs, some line control and reads
  task automatic random_calls(input int budget);
    int                 sent;
    int                 call_len;
    int                 pick;
    logic               cmd;
    logic               last;
    logic [CHAR_W-1:0]  ch;
    logic [INDEX_W-1:0] idx;
    sent = 0;
    while (sent < budget) begin
      call_len = $urandom_range(1, 40);
      for (int k = 0; k < call_len; k++) begin
        pick = $urandom_range(0, 99);
        cmd  = CMD_PUT;
        ch   = CHAR_W'($urandom_range(0, 255));
        idx  = INDEX_W'($urandom_range(0, MAX_INDEX));
        if (pick < 8) begin
          ch = CH_LF;
        end else if (pick < 12) begin
          ch = CH_CR;
        end else if (pick < 17) begin
          // read back around the cursor
          cmd = CMD_READ;
          idx = INDEX_W'((shadow.cursor == 0) ? 0 : shadow.cursor - 1);
        end else if (pick < 22) begin
          cmd = CMD_READ;
          idx = INDEX_W'($urandom_range(0, CELLS - 1));
        end else if (pick < 24) begin
          cmd = CMD_READ;
          idx = INDEX_W'($urandom_range(CELLS, MAX_INDEX));
        end
        last = (k == call_len - 1) || ($urandom_range(0, 49) == 0);
        put_beat(cmd, ch, idx, last);
        sent++;
      end
    end
  endtask

  initial begin
    logic [ATTR_W-1:0] phase_attr [6];
    shadow = new();
    phase_attr[0] = 8'h00;
    phase_attr[1] = 8'hFF;
    phase_attr[2] = ATTR_W'($urandom_range(0, 255));
    phase_attr[3] = 8'hA5;
    phase_attr[4] = ATTR_W'($urandom_range(0, 255));
    phase_attr[5] = ATTR_RESET;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Cleared store, reset attribute, then a new one
    put_beat(CMD_READ, 8'h00, 11'd0, 1'b0);
    put_beat(CMD_READ, 8'hFF, INDEX_W'(CELLS - 1), 1'b0);
    put_beat(CMD_PUT, 8'h41, 11'd0, 1'b0);
    settle();
    write_attr(8'h1E);
    put_beat(CMD_PUT, 8'h00, 11'd0, 1'b0);
    put_beat(CMD_PUT, 8'hFF, INDEX_W'(MAX_INDEX), 1'b0);
    put_beat(CMD_PUT, 8'h08, 11'd0, 1'b0);
    put_beat(CMD_PUT, 8'h09, 11'd0, 1'b1);
    put_beat(CMD_READ, 8'h00, INDEX_W'(CELLS), 1'b0);
    put_beat(CMD_READ, CH_CR, INDEX_W'(MAX_INDEX), 1'b1);
    put_beat(CMD_PUT, CH_CR, INDEX_W'(MAX_INDEX), 1'b0);
    put_beat(CMD_PUT, 8'h42, 11'd0, 1'b0);
    put_beat(CMD_PUT, CH_LF, 11'd0, 1'b0);
    put_beat(CMD_PUT, CH_CR, 11'd0, 1'b0);
    put_beat(CMD_PUT, 8'h7E, 11'd0, 1'b0);
    put_beat(CMD_PUT, CH_LF, 11'd0, 1'b1);
    put_beat(CMD_READ, 8'h00, 11'd0, 1'b0);
    put_beat(CMD_READ, 8'h00, 11'd1, 1'b0);
    put_beat(CMD_READ, 8'h00, 11'd2, 1'b0);
    put_beat(CMD_READ, 8'h00, 11'd3, 1'b0);
    put_beat(CMD_READ, 8'h00, INDEX_W'(COLUMNS), 1'b1);

    for (int p = 0; p < 6; p++) begin
      settle();
      write_attr(phase_attr[p]);
      if (p == 5) gaps_on = 1'b0;
      random_calls(230);
    end

    in_tvalid <= 1'b0;
    settle();
    if (shadow.bad_beats == 0 && shadow.due_status.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
